### rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants for the safe-allocation core
// Resource-kind count, handshake field codes, cell command and status
// structures, and the controller state type.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int KINDS    = 3;
	localparam int CLIENT_W = 3;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 4;

	// byte address of the active-client register, bit 2 selects register
	localparam logic [2:0] ADDR_ACTIVE = 3'd0;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_POOL  = 2'd1,
		ACT_REQ   = 2'd2,
		ACT_CHECK = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_LOADED  = 3'd0,
		STAT_SAFE    = 3'd1,
		STAT_NEED    = 3'd2,
		STAT_SHORT   = 3'd3,
		STAT_UNSAFE  = 3'd4,
		STAT_BADLOAD = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_APPLY,
		CMD_UNDO,
		CMD_CLEAR
	} cmd_op_t;

	typedef enum logic [1:0] {
		POOL_HOLD,
		POOL_SET,
		POOL_SUB,
		POOL_ADD
	} pool_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_START,
		S_INJECT,
		S_PASS,
		S_RESP
	} state_t;

	typedef struct packed {
		cmd_op_t op;
		logic    sel;
	} cell_cmd_t;

	typedef struct packed {
		logic done;
		logic over_need;
	} cell_stat_t;

endpackage

### rtl/bsa_cell.sv
// ----------------------------------------------------------------------------
// bsa_cell: one client row of the safety chain
// Holds the row's held and need amounts and its finished flag; takes the
// work vector from its left neighbor and hands it on in the next cycle.
// ----------------------------------------------------------------------------
module bsa_cell #(
	parameter int AMOUNT_WIDTH = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  bsa_pkg::cell_cmd_t                          cmd,
	input  logic                                        active,
	input  logic [bsa_pkg::KINDS-1:0][AMOUNT_WIDTH-1:0] amt,
	input  logic [bsa_pkg::KINDS-1:0][AMOUNT_WIDTH-1:0] hld,
	input  logic                                        tok_in,
	input  logic [bsa_pkg::KINDS-1:0][AMOUNT_WIDTH-1:0] work_in,
	input  logic                                        prog_in,
	output logic                                        tok_out,
	output logic [bsa_pkg::KINDS-1:0][AMOUNT_WIDTH-1:0] work_out,
	output logic                                        prog_out,
	output bsa_pkg::cell_stat_t                         stat
);
	import bsa_pkg::*;

	logic [KINDS-1:0][AMOUNT_WIDTH-1:0] held_q, need_q, work_q, sat_sum;
	logic done_q, tok_q, prog_q;
	logic fits, take, over;
	logic [AMOUNT_WIDTH:0] sum;

	always_comb begin
		fits = 1'b1;
		over = 1'b0;
		sum  = '0;
		for (int r = 0; r < KINDS; r++) begin
			if (need_q[r] > work_in[r]) fits = 1'b0;
			if (amt[r] > need_q[r]) over = 1'b1;
			sum = {1'b0, work_in[r]} + {1'b0, held_q[r]};
			// clamp at the amount maximum
			sat_sum[r] = sum[AMOUNT_WIDTH] ? '1 : sum[AMOUNT_WIDTH-1:0];
		end
		take = tok_in && active && !done_q && fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			need_q <= '0;
			done_q <= 1'b0;
			tok_q  <= 1'b0;
			prog_q <= 1'b0;
		end else begin
			tok_q  <= tok_in;
			prog_q <= prog_in | take;
			if (take) done_q <= 1'b1;
			case (cmd.op)
				CMD_LOAD: begin
					if (cmd.sel) begin
						for (int r = 0; r < KINDS; r++) begin
							held_q[r] <= hld[r];
							need_q[r] <= amt[r] - hld[r];
						end
					end
				end
				CMD_APPLY: begin
					if (cmd.sel) begin
						for (int r = 0; r < KINDS; r++) begin
							held_q[r] <= held_q[r] + amt[r];
							need_q[r] <= need_q[r] - amt[r];
						end
					end
				end
				CMD_UNDO: begin
					if (cmd.sel) begin
						for (int r = 0; r < KINDS; r++) begin
							held_q[r] <= held_q[r] - amt[r];
							need_q[r] <= need_q[r] + amt[r];
						end
					end
				end
				CMD_CLEAR: done_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		work_q <= take ? sat_sum : work_in;
	end

	assign tok_out        = tok_q;
	assign work_out       = work_q;
	assign prog_out       = prog_q;
	assign stat.done      = done_q;
	assign stat.over_need = cmd.sel && over;

endmodule

### rtl/bankers_safe_allocation_core.sv
// ----------------------------------------------------------------------------
// bankers_safe_allocation_core: safe allocator over three resource kinds
// Load, set-pool, request and check words; a request is granted only if a
// finish order exists for every active client row.
// Load, set-pool and denied request words go from the decide step straight to
// the response; granted requests and checks first run finish passes of the
// work vector, which walks the chain one row per cycle (passes: at most the
// clamped active row count, one when no row is active).
// One word is in work at a time: the next is taken in the cycle its result can
// first be handed off.
// Reset: tables and pool clear to zero, active_clients returns to 5.
// ----------------------------------------------------------------------------
module bankers_safe_allocation_core #(
	parameter int MAX_CLIENTS  = 8,
	parameter int AMOUNT_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// fields low to high: client, amount_a, amount_b, amount_c, held_a, held_b, held_c
	input  logic [((bsa_pkg::CLIENT_W + 6*AMOUNT_WIDTH + 7)/8)*8-1:0] s_tdata,
	// fields low to high: action
	input  logic [bsa_pkg::ACTION_W-1:0] s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// fields low to high: pool_a, pool_b, pool_c
	output logic [((3*AMOUNT_WIDTH + 7)/8)*8-1:0] m_tdata,
	// fields low to high: status
	output logic [bsa_pkg::STATUS_W-1:0] m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsa_pkg::*;

	localparam int W      = AMOUNT_WIDTH;
	localparam int CIDX_W = $clog2(MAX_CLIENTS);

	typedef logic [KINDS-1:0][W-1:0] vec_t;

	// --- configuration register ---
	logic [CFG_W-1:0] cfg_active_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_active_q <= ACTIVE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_ACTIVE[2]) begin
			cfg_active_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == ADDR_ACTIVE[2]) ? {{(32-CFG_W){1'b0}}, cfg_active_q} : '0;

	// wrap the client index onto the table depth
	function automatic logic [CIDX_W-1:0] wrap_client(input logic [CLIENT_W-1:0] c);
		int v;
		v = int'(c);
		for (int k = 0; k < 4; k++) begin
			if (v >= MAX_CLIENTS) v = v - MAX_CLIENTS;
		end
		return CIDX_W'(v);
	endfunction

	// --- unpack the input word ---
	vec_t in_amt, in_hld;

	always_comb begin
		for (int r = 0; r < KINDS; r++) begin
			in_amt[r] = s_tdata[CLIENT_W + r*W +: W];
			in_hld[r] = s_tdata[CLIENT_W + (KINDS + r)*W +: W];
		end
	end

	// --- latched word and controller state ---
	state_t            state_q, state_d;
	action_t           act_q;
	logic [CIDX_W-1:0] cli_q;
	vec_t              amt_q, hld_q, pool_q, loop_work_q;
	status_t           status_q;

	// --- cell chain wiring; index 0 is the injection point ---
	logic [MAX_CLIENTS:0] tok, prog;
	vec_t                 work [MAX_CLIENTS+1];
	cell_stat_t           stat [MAX_CLIENTS];
	logic [MAX_CLIENTS-1:0] act_vec, done_vec, over_vec;
	cmd_op_t              cmd_op;
	logic                 tok_inj, any_over, all_done, bad_load, short_pool;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_CLIENTS; gi++) begin : g_cell
			cell_cmd_t ccmd;
			assign ccmd.op  = cmd_op;
			assign ccmd.sel = (cli_q == CIDX_W'(gi));
			// rows beyond the active count pass the work on untouched
			assign act_vec[gi]  = (gi < int'(cfg_active_q));
			assign done_vec[gi] = stat[gi].done;
			assign over_vec[gi] = stat[gi].over_need;

			bsa_cell #(.AMOUNT_WIDTH(W)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (ccmd),
				.active   (act_vec[gi]),
				.amt      (amt_q),
				.hld      (hld_q),
				.tok_in   (tok[gi]),
				.work_in  (work[gi]),
				.prog_in  (prog[gi]),
				.tok_out  (tok[gi+1]),
				.work_out (work[gi+1]),
				.prog_out (prog[gi+1]),
				.stat     (stat[gi])
			);
		end
	endgenerate

	// inject a fresh pass; progress starts clear
	assign tok[0]  = tok_inj;
	assign work[0] = loop_work_q;
	assign prog[0] = 1'b0;

	assign any_over = |over_vec;
	// inactive rows count as finished
	assign all_done = &(done_vec | ~act_vec);

	always_comb begin
		bad_load   = 1'b0;
		short_pool = 1'b0;
		for (int r = 0; r < KINDS; r++) begin
			if (hld_q[r] > amt_q[r]) bad_load = 1'b1;
			if (amt_q[r] > pool_q[r]) short_pool = 1'b1;
		end
	end

	// --- output register ---
	logic    m_valid_q;
	status_t m_status_q;
	vec_t    m_pool_q;
	logic    out_free;

	assign out_free = !m_valid_q || m_tready;

	// --- next state ---
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (s_tvalid) state_d = S_DECIDE;
			S_DECIDE: begin
				unique case (act_q)
					ACT_LOAD, ACT_POOL: state_d = S_RESP;
					ACT_REQ:            state_d = (any_over || short_pool) ? S_RESP : S_START;
					ACT_CHECK:          state_d = S_START;
				endcase
			end
			S_START:  state_d = S_INJECT;
			S_INJECT: state_d = S_PASS;
			S_PASS: begin
				if (tok[MAX_CLIENTS]) begin
					state_d = (!all_done && prog[MAX_CLIENTS]) ? S_INJECT : S_RESP;
				end
			end
			S_RESP:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// --- controller outputs ---
	pool_op_t pool_op;
	logic     res_set, loop_ld_pool, loop_ld_last, out_load;
	status_t  res_code;

	always_comb begin
		cmd_op       = CMD_NONE;
		pool_op      = POOL_HOLD;
		res_set      = 1'b0;
		res_code     = STAT_LOADED;
		loop_ld_pool = 1'b0;
		loop_ld_last = 1'b0;
		tok_inj      = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_DECIDE: begin
				unique case (act_q)
					ACT_LOAD: begin
						res_set  = 1'b1;
						res_code = bad_load ? STAT_BADLOAD : STAT_LOADED;
						if (!bad_load) cmd_op = CMD_LOAD;
					end
					ACT_POOL: begin
						res_set  = 1'b1;
						res_code = STAT_LOADED;
						pool_op  = POOL_SET;
					end
					ACT_REQ: begin
						if (any_over) begin
							res_set  = 1'b1;
							res_code = STAT_NEED;
						end else if (short_pool) begin
							res_set  = 1'b1;
							res_code = STAT_SHORT;
						end else begin
							// grant tentatively
							cmd_op  = CMD_APPLY;
							pool_op = POOL_SUB;
						end
					end
					ACT_CHECK: ;
				endcase
			end
			S_START: begin
				cmd_op       = CMD_CLEAR;
				loop_ld_pool = 1'b1;
			end
			S_INJECT: tok_inj = 1'b1;
			S_PASS: begin
				if (tok[MAX_CLIENTS]) begin
					if (all_done) begin
						res_set  = 1'b1;
						res_code = STAT_SAFE;
					end else if (prog[MAX_CLIENTS]) begin
						loop_ld_last = 1'b1;
					end else begin
						res_set  = 1'b1;
						res_code = STAT_UNSAFE;
						// roll back an unsafe grant
						if (act_q == ACT_REQ) begin
							cmd_op  = CMD_UNDO;
							pool_op = POOL_ADD;
						end
					end
				end
			end
			S_RESP:  out_load = out_free;
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pool_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (pool_op)
				POOL_SET: pool_q <= amt_q;
				POOL_SUB: for (int r = 0; r < KINDS; r++) pool_q[r] <= pool_q[r] - amt_q[r];
				POOL_ADD: for (int r = 0; r < KINDS; r++) pool_q[r] <= pool_q[r] + amt_q[r];
				default: ;
			endcase
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// payload registers: word capture, loop work, result
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q <= action_t'(s_tuser);
			cli_q <= wrap_client(s_tdata[CLIENT_W-1:0]);
			amt_q <= in_amt;
			hld_q <= in_hld;
		end
		if (loop_ld_pool) loop_work_q <= pool_q;
		else if (loop_ld_last) loop_work_q <= work[MAX_CLIENTS];
		if (res_set) status_q <= res_code;
		if (out_load) begin
			m_status_q <= status_q;
			m_pool_q   <= pool_q;
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int r = 0; r < KINDS; r++) m_tdata[r*W +: W] = m_pool_q[r];
	end

	assign m_tuser  = m_status_q;
	assign m_tvalid = m_valid_q;

	// --- assertions ---
	a_tok_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_CLIENTS] |-> state_q == S_PASS)
		else $error("work vector left the chain outside a pass");

	a_pool_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(pool_q))
		else $error("free pool moved while idle");

	a_resp_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && state_d == S_IDLE) |=> m_tvalid)
		else $error("result not presented after response");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PASS || state_q == S_INJECT) |-> !s_tready)
		else $error("input accepted during safety test");

endmodule

### verif/tb_bankers_safe_allocation_core.sv
// ----------------------------------------------------------------------------
// tb_bankers_safe_allocation_core: self-checking bench for the safe allocator
// Drives load, set-pool, request and check words with random stalls on both
// stream sides. A scoreboard class keeps its own copy of the client tables,
// the free pool and the active-row count, works out the status and pool of
// each accepted word, and compares them with every returned word. The
// active-row register is rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_bankers_safe_allocation_core;
	import bsa_pkg::*;

	localparam int ROWS      = 8;
	localparam int AW        = 8;
	localparam int PHASES    = 6;
	localparam int PHASE_LEN = 150;
	localparam int TAIL_WAIT = 100;
	localparam int LIMIT     = 1000000;

	// one input word, resource A in the lowest byte of amt and held
	typedef struct packed {
		action_t             action;
		logic [2:0]          client;
		logic [2:0][AW-1:0]  amt;
		logic [2:0][AW-1:0]  held;
	} word_t;

	// one expected result word
	typedef struct packed {
		status_t             status;
		logic [2:0][AW-1:0]  pool;
	} reply_t;

	// ------------------------------------------------------------------------
	// Allocation tracker: predicts each result from its own tables
	// ------------------------------------------------------------------------
	class allocation_tracker;
		logic [AW-1:0] held_tab [ROWS][3];
		logic [AW-1:0] need_tab [ROWS][3];
		logic [AW-1:0] pool [3];
		logic [3:0]    active;
		reply_t        replies [$];
		int unsigned   bad_words;
		int unsigned   checked;
		int unsigned   status_seen [6];

		function new();
			foreach (held_tab[i, r]) begin
				held_tab[i][r] = '0;
				need_tab[i][r] = '0;
			end
			foreach (pool[r]) pool[r] = '0;
			active    = ACTIVE_RESET;
			bad_words = 0;
			checked   = 0;
			foreach (status_seen[k]) status_seen[k] = 0;
		endfunction

		// finish passes over the active rows until all finish or none moves
		function bit finish_order_exists();
			logic [AW-1:0] work [3];
			logic [AW:0]   sum;
			bit            done [ROWS];
			int            rows, finished;
			bit            progress, fits;
			rows     = (int'(active) > ROWS) ? ROWS : int'(active);
			finished = 0;
			foreach (work[r]) work[r] = pool[r];
			foreach (done[i]) done[i] = 1'b0;
			while (finished < rows) begin
				progress = 1'b0;
				for (int i = 0; i < rows; i++) begin
					if (!done[i]) begin
						fits = 1'b1;
						for (int r = 0; r < 3; r++)
							if (need_tab[i][r] > work[r]) fits = 1'b0;
						if (fits) begin
							for (int r = 0; r < 3; r++) begin
								sum     = {1'b0, work[r]} + {1'b0, held_tab[i][r]};
								work[r] = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
							end
							done[i]  = 1'b1;
							finished++;
							progress = 1'b1;
						end
					end
				end
				if (!progress) break;
			end
			return finished == rows;
		endfunction

		// update the tables for an accepted word and queue its result
		function void note_word(word_t w);
			reply_t exp;
			bit     bad, over_need, short_pool;
			int     c;
			c          = int'(w.client);
			bad        = 1'b0;
			over_need  = 1'b0;
			short_pool = 1'b0;
			case (w.action)
				ACT_LOAD: begin
					for (int r = 0; r < 3; r++)
						if (w.held[r] > w.amt[r]) bad = 1'b1;
					if (bad) begin
						exp.status = STAT_BADLOAD;
					end else begin
						for (int r = 0; r < 3; r++) begin
							held_tab[c][r] = w.held[r];
							need_tab[c][r] = w.amt[r] - w.held[r];
						end
						exp.status = STAT_LOADED;
					end
				end
				ACT_POOL: begin
					for (int r = 0; r < 3; r++) pool[r] = w.amt[r];
					exp.status = STAT_LOADED;
				end
				ACT_REQ: begin
					for (int r = 0; r < 3; r++) begin
						if (w.amt[r] > need_tab[c][r]) over_need = 1'b1;
						if (w.amt[r] > pool[r]) short_pool = 1'b1;
					end
					if (over_need) begin
						exp.status = STAT_NEED;
					end else if (short_pool) begin
						exp.status = STAT_SHORT;
					end else begin
						// grant tentatively, roll back if no finish order exists
						for (int r = 0; r < 3; r++) begin
							pool[r]        = pool[r] - w.amt[r];
							held_tab[c][r] = held_tab[c][r] + w.amt[r];
							need_tab[c][r] = need_tab[c][r] - w.amt[r];
						end
						if (finish_order_exists()) begin
							exp.status = STAT_SAFE;
						end else begin
							for (int r = 0; r < 3; r++) begin
								pool[r]        = pool[r] + w.amt[r];
								held_tab[c][r] = held_tab[c][r] - w.amt[r];
								need_tab[c][r] = need_tab[c][r] + w.amt[r];
							end
							exp.status = STAT_UNSAFE;
						end
					end
				end
				default: begin
					exp.status = finish_order_exists() ? STAT_SAFE : STAT_UNSAFE;
				end
			endcase
			for (int r = 0; r < 3; r++) exp.pool[r] = pool[r];
			replies.push_back(exp);
		endfunction

		// compare one returned word with the oldest expectation
		function void check_result(logic [STATUS_W-1:0] st, logic [3*AW-1:0] pools);
			reply_t exp;
			bit     wrong;
			checked++;
			if (replies.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("result %0d arrived with nothing expected: status %0d pools %h",
						checked, st, pools);
				return;
			end
			exp   = replies.pop_front();
			wrong = (st != exp.status);
			for (int r = 0; r < 3; r++)
				if (pools[AW*r +: AW] != exp.pool[r]) wrong = 1'b1;
			if (st < 6) status_seen[st]++;
			if (wrong) begin
				bad_words++;
				if (bad_words <= 10) begin
					$display("result %0d mismatch: status exp %0d got %0d",
						checked, exp.status, st);
					$display("  pool a/b/c exp %0d/%0d/%0d got %0d/%0d/%0d",
						exp.pool[0], exp.pool[1], exp.pool[2],
						pools[7:0], pools[15:8], pools[23:16]);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n;
	logic [55:0]          s_tdata;
	logic [ACTION_W-1:0]  s_tuser;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [23:0]          m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic                 psel, penable, pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	allocation_tracker    sb;
	bit                   no_idle;
	int unsigned          cycle_count;
	int unsigned          words_sent;

	bankers_safe_allocation_core #(
		.MAX_CLIENTS (ROWS),
		.AMOUNT_WIDTH(AW)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bound the run; a hang in the core lands here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// stall the result side at random, except during the no-idle stretch
	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 37);
	end

	// sample pre-edge values: a word moves when tvalid and tready were high
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	function automatic word_t mk(action_t a, int c, int a0, int a1, int a2,
		int h0, int h1, int h2);
		word_t w;
		w.action  = a;
		w.client  = c[2:0];
		w.amt[0]  = a0[AW-1:0];
		w.amt[1]  = a1[AW-1:0];
		w.amt[2]  = a2[AW-1:0];
		w.held[0] = h0[AW-1:0];
		w.held[1] = h1[AW-1:0];
		w.held[2] = h2[AW-1:0];
		return w;
	endfunction

	// present one word, optionally after a gap, and hold it until accepted
	task automatic send_word(word_t w);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 99) < 37)
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {5'b0, w.held, w.amt, w.client};
		s_tuser  <= w.action;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_word(w);
		words_sent++;
	endtask

	// drop valid and wait until every expected word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.replies.size() != 0) @(posedge clk);
	endtask

	// setup cycle, then access cycle held until pready
	task automatic write_active(logic [3:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ACTIVE;
		pwdata  <= {28'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.active = value;
	endtask

	// mostly well-formed traffic: consistent loads, requests within need
	function automatic word_t random_word();
		word_t w;
		int    pick, c, lim;
		pick     = $urandom_range(0, 99);
		c        = $urandom_range(0, ROWS - 1);
		w.client = c[2:0];
		w.held   = '0;
		for (int r = 0; r < 3; r++) w.amt[r] = AW'($urandom);
		if (pick < 20) begin
			w.action = ACT_LOAD;
			for (int r = 0; r < 3; r++) begin
				if ($urandom_range(0, 9) < 7) w.amt[r] = AW'($urandom_range(0, 40));
				if ($urandom_range(0, 99) < 85) w.held[r] = AW'($urandom_range(0, w.amt[r]));
				else w.held[r] = AW'($urandom);
			end
		end else if (pick < 30) begin
			w.action = ACT_POOL;
			if ($urandom_range(0, 9) < 8)
				for (int r = 0; r < 3; r++) w.amt[r] = AW'($urandom_range(0, 80));
		end else if (pick < 85) begin
			w.action = ACT_REQ;
			if ($urandom_range(0, 99) < 75) begin
				for (int r = 0; r < 3; r++) begin
					lim = int'((sb.need_tab[c][r] < sb.pool[r]) ? sb.need_tab[c][r]
						: sb.pool[r]);
					w.amt[r] = AW'($urandom_range(0, lim));
				end
			end else if ($urandom_range(0, 1) == 0) begin
				// small amounts on every kind, which may pass need or pool
				for (int r = 0; r < 3; r++) w.amt[r] = AW'($urandom_range(0, 8));
			end
		end else begin
			w.action = ACT_CHECK;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	logic [3:0] phase_active [PHASES] = '{4'd3, 4'd8, 4'd1, 4'd0, 4'd15, 4'd6};

	initial begin
		sb          = new();
		no_idle     = 1'b0;
		cycle_count = 0;
		words_sent  = 0;
		arst_n      = 1'b0;
		s_tdata     = '0;
		s_tuser     = ACT_LOAD;
		s_tvalid    = 1'b0;
		m_tready    = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset state, then each status and the edge cases
		send_word(mk(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0));          // empty tables are safe
		send_word(mk(ACT_REQ, 0, 0, 0, 0, 0, 0, 0));            // zero request grants
		send_word(mk(ACT_LOAD, 0, 255, 255, 255, 255, 255, 255)); // full hold, no need
		send_word(mk(ACT_LOAD, 1, 10, 20, 30, 11, 0, 0));       // held above maximum
		send_word(mk(ACT_LOAD, 1, 10, 20, 30, 2, 3, 4));
		send_word(mk(ACT_POOL, 0, 255, 0, 255, 0, 0, 0));
		send_word(mk(ACT_REQ, 1, 9, 0, 0, 0, 0, 0));            // beyond need
		send_word(mk(ACT_REQ, 1, 1, 1, 1, 0, 0, 0));            // pool short on B
		send_word(mk(ACT_POOL, 0, 5, 5, 5, 0, 0, 0));
		send_word(mk(ACT_REQ, 1, 1, 1, 1, 0, 0, 0));            // saturating work sum
		send_word(mk(ACT_LOAD, 2, 200, 200, 200, 0, 0, 0));
		send_word(mk(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0));          // rows 1 and 2 block: unsafe
		send_word(mk(ACT_REQ, 1, 1, 1, 1, 0, 0, 0));            // rolled back
		send_word(mk(ACT_LOAD, 7, 255, 255, 255, 0, 0, 0));     // row outside active set
		send_word(mk(ACT_LOAD, 2, 0, 0, 0, 0, 0, 0));
		send_word(mk(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(ACT_REQ, 7, 4, 4, 4, 0, 0, 0));            // inactive row, refused as unsafe since row 1 blocks
		send_word(mk(ACT_POOL, 0, 255, 255, 255, 0, 0, 0));
		send_word(mk(ACT_LOAD, 4, 255, 255, 255, 255, 255, 255));
		drain();
		write_active(4'd8);
		send_word(mk(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0));
		drain();
		write_active(4'd0);                                     // no rows: always safe
		send_word(mk(ACT_POOL, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0));
		drain();
		write_active(4'd15);                                    // clamps to the table size
		send_word(mk(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0));
		drain();

		// random phases, each under its own active-row count
		for (int p = 0; p < PHASES; p++) begin
			write_active(phase_active[p]);
			no_idle = (p == 2);
			for (int k = 0; k < PHASE_LEN; k++) begin
				send_word(random_word());
				// hold off mid-phase until the core has answered everything
				if (p == 0 && k == PHASE_LEN / 2) drain();
			end
			drain();
		end
		no_idle = 1'b0;
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Sent %0d words, checked %0d results under active counts 5, 8, 0, 15, 3, 1, 6",
			words_sent, sb.checked);
		$display("Statuses seen: loaded %0d, safe %0d, need %0d, short %0d, unsafe %0d, badload %0d",
			sb.status_seen[STAT_LOADED], sb.status_seen[STAT_SAFE], sb.status_seen[STAT_NEED],
			sb.status_seen[STAT_SHORT], sb.status_seen[STAT_UNSAFE], sb.status_seen[STAT_BADLOAD]);
		if (sb.bad_words == 0 && sb.replies.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d bad results, %0d expectations left", sb.bad_words, sb.replies.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
